// File: hdl/anp_pkg.sv
// ============================================================================
// anp_pkg
// Types and constants shared by the ASCII number parser modules.
// ============================================================================
package anp_pkg;

    localparam int unsigned CharWidth  = 8;
    localparam int unsigned ValueWidth = 32;

    // Bytes below this code are blanks.
    localparam logic [CharWidth-1:0] BlankLimit = 8'h21;
    // Decimal radix; the multiply is built as (x << 3) + (x << 1).
    localparam int unsigned DecRadix = 10;

    localparam logic [CharWidth-1:0] ChPlus   = 8'h2B;
    localparam logic [CharWidth-1:0] ChMinus  = 8'h2D;
    localparam logic [CharWidth-1:0] ChDollar = 8'h24;
    localparam logic [CharWidth-1:0] ChZero   = 8'h30;
    localparam logic [CharWidth-1:0] ChNine   = 8'h39;
    localparam logic [CharWidth-1:0] ChLowA   = 8'h61;
    localparam logic [CharWidth-1:0] ChLowF   = 8'h66;
    localparam logic [CharWidth-1:0] ChUpA    = 8'h41;
    localparam logic [CharWidth-1:0] ChUpF    = 8'h46;
    localparam logic [CharWidth-1:0] ChLowX   = 8'h78;
    localparam logic [CharWidth-1:0] ChUpX    = 8'h58;

    typedef enum logic [2:0] {
        PH_SKIP  = 3'd0,
        PH_PLUS  = 3'd1,
        PH_MINUS = 3'd2,
        PH_PREF  = 3'd3,
        PH_ZERO  = 3'd4,
        PH_DEC   = 3'd5,
        PH_HEX   = 3'd6,
        PH_DONE  = 3'd7
    } t_phase;

    typedef struct packed {
        t_phase                phase;
        logic                  neg;
        logic [ValueWidth-1:0] acc;
    } t_parse_state;

    localparam t_parse_state ParseReset = '{phase: PH_SKIP, neg: 1'b0, acc: '0};

endpackage

// File: hdl/anp_char_step.sv
// ============================================================================
// anp_char_step
// One character of parsing: next parser state and the value for end of string.
// ============================================================================
module anp_char_step (
    input  anp_pkg::t_parse_state              i_state,
    input  logic [anp_pkg::CharWidth-1:0]      i_char,
    input  logic                               i_last,
    output anp_pkg::t_parse_state              o_state,
    output logic [anp_pkg::ValueWidth-1:0]     o_value
);

    logic                              w_is_dec;
    logic                              w_is_lo_hex;
    logic                              w_is_up_hex;
    logic [3:0]                        w_dec_digit;
    logic [3:0]                        w_hex_digit;
    logic [anp_pkg::ValueWidth-1:0]    w_acc_dec;
    logic [anp_pkg::ValueWidth-1:0]    w_acc_hex;
    anp_pkg::t_parse_state             w_next;

    assign w_is_dec    = (i_char >= anp_pkg::ChZero) && (i_char <= anp_pkg::ChNine);
    assign w_is_lo_hex = (i_char >= anp_pkg::ChLowA) && (i_char <= anp_pkg::ChLowF);
    assign w_is_up_hex = (i_char >= anp_pkg::ChUpA)  && (i_char <= anp_pkg::ChUpF);
    assign w_dec_digit = i_char[3:0];
    // 'a'..'f' and 'A'..'F' both have low nibble 1..6
    assign w_hex_digit = w_is_dec ? i_char[3:0] : (i_char[3:0] + 4'd9);

    assign w_acc_dec = (i_state.acc << 3) + (i_state.acc << 1)
                     + {{(anp_pkg::ValueWidth-4){1'b0}}, w_dec_digit};
    assign w_acc_hex = {i_state.acc[anp_pkg::ValueWidth-5:0], w_hex_digit};

    // Next state: walk the phases in order until one consumes the character.
    always_comb begin
        anp_pkg::t_phase ph;
        logic            done;
        ph     = i_state.phase;
        done   = 1'b0;
        w_next = i_state;
        if (ph == anp_pkg::PH_SKIP) begin
            if (i_char < anp_pkg::BlankLimit) begin
                done = 1'b1;
            end else begin
                ph = anp_pkg::PH_PLUS;
            end
        end
        if (!done && ph == anp_pkg::PH_PLUS) begin
            if (i_char == anp_pkg::ChPlus) begin
                w_next.phase = anp_pkg::PH_MINUS;
                done         = 1'b1;
            end else begin
                ph = anp_pkg::PH_MINUS;
            end
        end
        if (!done && ph == anp_pkg::PH_MINUS) begin
            if (i_char == anp_pkg::ChMinus) begin
                w_next.neg   = 1'b1;
                w_next.phase = anp_pkg::PH_PREF;
                done         = 1'b1;
            end else begin
                ph = anp_pkg::PH_PREF;
            end
        end
        if (!done && ph == anp_pkg::PH_PREF) begin
            if (i_char == anp_pkg::ChDollar) begin
                w_next.phase = anp_pkg::PH_HEX;
                done         = 1'b1;
            end else if (i_char == anp_pkg::ChZero) begin
                w_next.acc   = '0;
                w_next.phase = anp_pkg::PH_ZERO;
                done         = 1'b1;
            end else begin
                ph = anp_pkg::PH_DEC;
            end
        end
        if (!done && ph == anp_pkg::PH_ZERO) begin
            if (i_char == anp_pkg::ChLowX || i_char == anp_pkg::ChUpX) begin
                w_next.phase = anp_pkg::PH_HEX;
                done         = 1'b1;
            end else begin
                ph = anp_pkg::PH_DEC;
            end
        end
        if (!done && ph == anp_pkg::PH_DEC) begin
            done = 1'b1;
            if (w_is_dec) begin
                w_next.acc   = w_acc_dec;
                w_next.phase = anp_pkg::PH_DEC;
            end else begin
                w_next.phase = anp_pkg::PH_DONE;
            end
        end
        if (!done && ph == anp_pkg::PH_HEX) begin
            if (w_is_dec || w_is_lo_hex || w_is_up_hex) begin
                w_next.acc = w_acc_hex;
            end else begin
                w_next.phase = anp_pkg::PH_DONE;
            end
        end
    end

    // Outputs: state returns to reset after the flagged character.
    always_comb begin
        o_state = i_last ? anp_pkg::ParseReset : w_next;
        o_value = w_next.neg ? ('0 - w_next.acc) : w_next.acc;
    end

endmodule

// File: hdl/ascii_number_parser.sv
// ============================================================================
// ascii_number_parser
// Streams characters in, emits the signed 32-bit value at each end of string.
// ============================================================================
//
//  channel  dir  tdata                     tlast          tuser
//  s_axis   in   [7:0] char_code           end_of_string  -
//  m_axis   out  [31:0] parsed_value       -              -
//
//  One character per cycle unless stalled. A character is parsed in the
//  cycle it is accepted; the parser state (phase, sign, accumulator) is
//  updated at that edge. On the flagged last character the value is loaded
//  into the output register at that same edge and offered from the next
//  cycle. The decimal multiply-add plus final negation is the longest path.
//  Reset (i_rst_n low, synchronous) returns the parser to blank skipping and
//  empties the output register.
//  Input is taken while the output register is empty or being drained, so a
//  held result that is not being taken stalls every character, not only the
//  last one of the next string.
//
module ascii_number_parser (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [anp_pkg::CharWidth-1:0]     s_axis_tdata,   // [7:0] char_code
    input  logic                              s_axis_tlast,   // end_of_string
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [anp_pkg::ValueWidth-1:0]    m_axis_tdata    // [31:0] parsed_value
);

    anp_pkg::t_parse_state             r_state;
    anp_pkg::t_parse_state             n_state;
    logic [anp_pkg::ValueWidth-1:0]    r_value;
    logic [anp_pkg::ValueWidth-1:0]    w_value;
    logic                              r_out_valid;
    logic                              w_in_fire;

    // Output register is free when empty or taken in this same cycle.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;

    anp_char_step u_step (
        .i_state (r_state),
        .i_char  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .o_state (n_state),
        .o_value (w_value)
    );

    // Parser state advances only on an accepted character.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= anp_pkg::ParseReset;
        end else if (w_in_fire) begin
            r_state <= n_state;
        end
    end

    // Result register: loads on the last character of a string.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_fire && s_axis_tlast) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire && s_axis_tlast) begin
            r_value <= w_value;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_value;

endmodule
